[rtl/etl_pkg.sv]
// Shared types, token codes and character classes for the expression token lexer.
`timescale 1ns / 1ps

package etl_pkg;

    localparam int CHAR_W  = 8;
    localparam int TYPE_W  = 4;
    localparam int USER_W  = TYPE_W + 2;

    // Token type codes
    localparam logic [TYPE_W-1:0] TOK_SCALAR = 4'd0;
    localparam logic [TYPE_W-1:0] TOK_MATRIX = 4'd1;
    localparam logic [TYPE_W-1:0] TOK_PLUS   = 4'd2;
    localparam logic [TYPE_W-1:0] TOK_MINUS  = 4'd3;
    localparam logic [TYPE_W-1:0] TOK_MULT   = 4'd4;
    localparam logic [TYPE_W-1:0] TOK_DIVIDE = 4'd5;
    localparam logic [TYPE_W-1:0] TOK_LPAREN = 4'd6;
    localparam logic [TYPE_W-1:0] TOK_RPAREN = 4'd7;
    localparam logic [TYPE_W-1:0] TOK_END    = 4'd8;
    localparam logic [TYPE_W-1:0] TOK_ERROR  = 4'd9;

    // Lexer mode codes
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_SCALAR = 2'd1;
    localparam logic [1:0] MODE_MATRIX = 2'd2;
    localparam logic [1:0] MODE_DASH   = 2'd3;

    // Characters of interest
    localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_DASH   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;

    // One result beat
    typedef struct packed {
        logic [TYPE_W-1:0] tok_type;
        logic [CHAR_W-1:0] tok_char;
        logic              tok_first;
        logic              tok_last;
        logic              run_last;
    } t_result;

    function automatic logic is_ws(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic logic is_scalar_char(input logic [CHAR_W-1:0] c);
        return ((c >= CH_ZERO) && (c <= CH_NINE)) || (c == CH_DASH) || (c == CH_DOT);
    endfunction

    function automatic logic is_op(input logic [CHAR_W-1:0] c);
        return (c == CH_PLUS) || (c == CH_DASH) || (c == CH_STAR) || (c == CH_SLASH);
    endfunction

endpackage

[rtl/expression_token_lexer.sv]
// Expression token lexer: classifies one character per beat and queues its token beats.
// A character's beats enter the result queue when the next beat is accepted (the end beat's
// own results enter when it is accepted) and are offered from the registered queue head.
// Throughput: one input beat per cycle while the queue holds at most one entry; a beat giving
// more results stalls the input while the four-entry queue drains, longer under back-pressure.
// Reset (synchronous, active low) returns the lexer to idle and empties the queue.
`timescale 1ns / 1ps

module expression_token_lexer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [etl_pkg::CHAR_W-1:0]   i_s_axis_tdata,   // [7:0] character
    input  logic                         i_s_axis_tlast,   // end_of_text
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    output logic [etl_pkg::CHAR_W-1:0]   o_m_axis_tdata,   // [7:0] token_char
    output logic [etl_pkg::USER_W-1:0]   o_m_axis_tuser,   // [3:0] token_type, [4] first, [5] last
    output logic                         o_m_axis_tlast    // last_of_run
);
    import etl_pkg::*;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int MAXRES = 3;

    // Lexer state
    logic [1:0]        r_mode,   n_mode;
    logic [CHAR_W-1:0] r_hchar,  n_hchar;
    logic              r_hvalid, n_hvalid;
    logic [TYPE_W-1:0] r_htype,  n_htype;
    logic              r_hfirst, n_hfirst;
    logic              r_prior,  n_prior;
    logic              r_err,    n_err;

    // Result queue
    t_result           r_q [QDEPTH];
    logic [QAW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [QAW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [QAW:0]      r_count,  n_count;

    t_result           res [MAXRES];
    logic [1:0]        res_cnt;
    logic              accept;
    logic              pop;
    t_result           head;

    assign accept = i_s_axis_tvalid && o_s_axis_tready;
    assign pop    = o_m_axis_tvalid && i_m_axis_tready;
    assign o_s_axis_tready = (r_count <= (QAW+1)'(1));

    // Lexer decision for the current input beat
    always_comb begin
        logic [CHAR_W-1:0] ch;
        logic              fin;
        logic              fresh;
        logic              cont;
        ch    = i_s_axis_tdata;
        fin   = i_s_axis_tlast;
        fresh = 1'b1;
        cont  = 1'b0;

        n_mode   = r_mode;
        n_hchar  = r_hchar;
        n_hvalid = r_hvalid;
        n_htype  = r_htype;
        n_hfirst = r_hfirst;
        n_prior  = r_prior;
        n_err    = r_err;
        res_cnt  = 2'd0;
        for (int i = 0; i < MAXRES; i++) begin
            res[i] = '0;
        end

        if (r_err) begin
            res[res_cnt] = '{TOK_ERROR, ch, 1'b1, 1'b1, 1'b0};
            res_cnt = res_cnt + 2'd1;
        end else begin
            // Release the held character
            if (r_hvalid) begin
                unique case (r_mode)
                    MODE_SCALAR: begin
                        cont = is_scalar_char(ch);
                        res[res_cnt] = '{TOK_SCALAR, r_hchar, r_hfirst, !cont, 1'b0};
                        res_cnt = res_cnt + 2'd1;
                        if (cont) begin
                            n_htype = TOK_SCALAR; n_hchar = ch; n_hfirst = 1'b0;
                            n_hvalid = 1'b1; n_mode = MODE_SCALAR;
                            fresh = 1'b0;
                        end else begin
                            n_hvalid = 1'b0; n_mode = MODE_IDLE;
                        end
                    end
                    MODE_DASH: begin
                        if (is_ws(ch)) begin
                            res[res_cnt] = '{TOK_MINUS, r_hchar, 1'b1, 1'b1, 1'b0};
                            res_cnt = res_cnt + 2'd1;
                            n_hvalid = 1'b0; n_mode = MODE_IDLE;
                        end else begin
                            cont = is_scalar_char(ch);
                            res[res_cnt] = '{TOK_SCALAR, r_hchar, 1'b1, !cont, 1'b0};
                            res_cnt = res_cnt + 2'd1;
                            if (cont) begin
                                n_htype = TOK_SCALAR; n_hchar = ch; n_hfirst = 1'b0;
                                n_hvalid = 1'b1; n_mode = MODE_SCALAR;
                                fresh = 1'b0;
                            end else begin
                                n_hvalid = 1'b0; n_mode = MODE_IDLE;
                            end
                        end
                    end
                    MODE_MATRIX: begin
                        res[res_cnt] = '{TOK_MATRIX, r_hchar, r_hfirst, 1'b0, 1'b0};
                        res_cnt = res_cnt + 2'd1;
                        n_htype = TOK_MATRIX; n_hchar = ch; n_hfirst = 1'b0;
                        n_hvalid = 1'b1;
                        n_mode = (ch == CH_RBRACK) ? MODE_IDLE : MODE_MATRIX;
                        fresh = 1'b0;
                    end
                    default: begin
                        res[res_cnt] = '{r_htype, r_hchar, r_hfirst, 1'b1, 1'b0};
                        res_cnt = res_cnt + 2'd1;
                        n_hvalid = 1'b0; n_mode = MODE_IDLE;
                    end
                endcase
            end

            // Classify a character that starts something new
            if (fresh) begin
                n_hvalid = 1'b0;
                n_mode   = MODE_IDLE;
                n_hchar  = ch;
                n_hfirst = 1'b1;
                priority if (is_ws(ch)) begin
                    n_hchar = r_hchar;
                    n_hfirst = r_hfirst;
                end else if (ch == CH_LBRACK) begin
                    n_htype = TOK_MATRIX; n_hvalid = 1'b1; n_mode = MODE_MATRIX;
                end else if (ch == CH_PLUS) begin
                    n_htype = TOK_PLUS; n_hvalid = 1'b1;
                end else if (ch == CH_STAR) begin
                    n_htype = TOK_MULT; n_hvalid = 1'b1;
                end else if (ch == CH_SLASH) begin
                    n_htype = TOK_DIVIDE; n_hvalid = 1'b1;
                end else if (ch == CH_LPAREN) begin
                    n_htype = TOK_LPAREN; n_hvalid = 1'b1;
                end else if (ch == CH_RPAREN) begin
                    n_htype = TOK_RPAREN; n_hvalid = 1'b1;
                end else if (ch == CH_DASH) begin
                    n_hvalid = 1'b1;
                    if (r_prior) begin
                        n_htype = TOK_SCALAR; n_mode = MODE_DASH;
                    end else begin
                        n_htype = TOK_MINUS;
                    end
                end else if (is_scalar_char(ch)) begin
                    n_htype = TOK_SCALAR; n_hvalid = 1'b1; n_mode = MODE_SCALAR;
                end else begin
                    // Unknown character: error beat, then sticky error
                    n_hchar = r_hchar;
                    n_hfirst = r_hfirst;
                    res[res_cnt] = '{TOK_ERROR, ch, 1'b1, 1'b1, 1'b0};
                    res_cnt = res_cnt + 2'd1;
                    n_err = 1'b1;
                end
            end

            if (!is_ws(ch)) begin
                n_prior = is_op(ch);
            end
        end

        // End of text: flush, end token, back to reset state
        if (fin) begin
            if (!n_err && n_hvalid) begin
                unique case (n_mode)
                    MODE_MATRIX: res[res_cnt] = '{TOK_ERROR, n_hchar, 1'b1, 1'b1, 1'b0};
                    MODE_DASH:   res[res_cnt] = '{TOK_SCALAR, n_hchar, 1'b1, 1'b1, 1'b0};
                    default:     res[res_cnt] = '{n_htype, n_hchar, n_hfirst, 1'b1, 1'b0};
                endcase
                res_cnt = res_cnt + 2'd1;
            end
            res[res_cnt] = '{TOK_END, '0, 1'b1, 1'b1, 1'b0};
            res_cnt = res_cnt + 2'd1;
            n_mode   = MODE_IDLE;
            n_hchar  = '0;
            n_hvalid = 1'b0;
            n_htype  = '0;
            n_hfirst = 1'b0;
            n_prior  = 1'b1;
            n_err    = 1'b0;
        end

        // Mark the final beat of this run
        if (res_cnt != 2'd0) begin
            res[res_cnt - 2'd1].run_last = 1'b1;
        end
    end

    // Queue pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (accept) begin
            n_wr_ptr = r_wr_ptr + QAW'(res_cnt);
            n_count  = n_count + (QAW+1)'(res_cnt);
        end
        if (pop) begin
            n_rd_ptr = r_rd_ptr + QAW'(1);
            n_count  = n_count - (QAW+1)'(1);
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_hchar  <= '0;
            r_hvalid <= 1'b0;
            r_htype  <= '0;
            r_hfirst <= 1'b0;
            r_prior  <= 1'b1;
            r_err    <= 1'b0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (accept) begin
                r_mode   <= n_mode;
                r_hchar  <= n_hchar;
                r_hvalid <= n_hvalid;
                r_htype  <= n_htype;
                r_hfirst <= n_hfirst;
                r_prior  <= n_prior;
                r_err    <= n_err;
            end
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Result queue storage
    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < MAXRES; i++) begin
                if (2'(i) < res_cnt) begin
                    r_q[r_wr_ptr + QAW'(i)] <= res[i];
                end
            end
        end
    end

    // Output beat from the queue head
    assign head            = r_q[r_rd_ptr];
    assign o_m_axis_tvalid = (r_count != '0);
    assign o_m_axis_tdata  = head.tok_char;
    assign o_m_axis_tuser  = {head.tok_last, head.tok_first, head.tok_type};
    assign o_m_axis_tlast  = head.run_last;

endmodule
